/* rtl/pisr_pkg.sv */
// Shared types and constants of the power-iteration eigenvalue estimator.
package pisr_pkg;

  localparam int MaxStates = 16;
  localparam int IdxW      = 4;
  localparam int AddrW     = 2 * IdxW;
  localparam int Depth     = MaxStates * MaxStates;

  localparam logic [1:0] CFG_ACTIVE_STATES = 2'd0;
  localparam logic [1:0] CFG_MAX_ITER      = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE     = 2'd2;

  localparam logic [4:0]  ActiveReset = 5'd16;
  localparam logic [9:0]  MaxIterReset = 10'd1000;
  localparam logic [15:0] TolReset     = 16'd1;

  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  typedef struct packed {
    logic [3:0]         entry_row;
    logic [3:0]         entry_col;
    logic signed [15:0] entry_value;
    logic               last_entry;
  } item_t;

  typedef struct packed {
    logic [31:0]        eigen_estimate;
    logic signed [23:0] log2_capacity;
    logic [9:0]         passes_used;
    logic               zero_norm;
  } result_t;

endpackage

/* rtl/pisr_if.sv */
// Channel interfaces for matrix entries and results.
interface pisr_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         entry_row;
  logic [3:0]         entry_col;
  logic signed [15:0] entry_value;
  logic               last_entry;
  modport source(output valid, entry_row, entry_col, entry_value, last_entry, input ready);
  modport sink(input valid, entry_row, entry_col, entry_value, last_entry, output ready);
endinterface

interface pisr_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        eigen_estimate;
  logic signed [23:0] log2_capacity;
  logic [9:0]         passes_used;
  logic               zero_norm;
  modport source(output valid, eigen_estimate, log2_capacity, passes_used, zero_norm,
                 input ready);
  modport sink(input valid, eigen_estimate, log2_capacity, passes_used, zero_norm,
               output ready);
endinterface

/* rtl/pisr_front.sv */
// Input stage: takes entries and holds them in a two-entry queue for the engine.
module pisr_front (
  input  logic            clk,
  input  logic            rst_n,
  pisr_in_if.sink         in_ch,
  output pisr_pkg::item_t q_item,
  output logic            q_valid,
  input  logic            q_ready
);
  import pisr_pkg::*;

  item_t      slot_r [2];
  logic       head_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  item_t      in_item;

  assign in_item.entry_row   = in_ch.entry_row;
  assign in_item.entry_col   = in_ch.entry_col;
  assign in_item.entry_value = in_ch.entry_value;
  assign in_item.last_entry  = in_ch.last_entry;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = slot_r[head_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[head_r ^ cnt_r[0]] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (pop) begin
        head_r <= ~head_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/pisr_engine.sv */
// Matrix store, power-iteration sequencer and result register.
module pisr_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  pisr_pkg::item_t q_item,
  input  logic            q_valid,
  output logic            q_ready,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [15:0]     cfg_data,
  pisr_out_if.source      out_ch
);
  import pisr_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_RD   = 16'h0002, S_MUL  = 16'h0004, S_ACC  = 16'h0008,
    S_ROW  = 16'h0010, S_SQ   = 16'h0020, S_SUM  = 16'h0040, S_SQRT = 16'h0080,
    S_DLD  = 16'h0100, S_DIV  = 16'h0200, S_DWB  = 16'h0400, S_CONV = 16'h0800,
    S_LNRM = 16'h1000, S_LSQ  = 16'h2000, S_LST  = 16'h4000, S_FIN  = 16'h8000
  } state_t;

  state_t state_r;

  logic [4:0]  act_r;
  logic [9:0]  max_it_r;
  logic [15:0] tol_r;

  logic signed [15:0] mem [Depth];
  logic [Depth-1:0]   valid_r;
  logic signed [15:0] rd_data_r;
  logic               rd_vld_r;
  logic [AddrW-1:0]   raddr;
  logic               mem_we;

  logic signed [31:0] x_r [MaxStates];
  logic signed [47:0] y_r [MaxStates];
  logic [4:0]         n_r, i_r, j_r;
  logic signed [47:0] prod_r;
  logic signed [51:0] acc_r;
  logic [27:0]        q_r;
  logic [55:0]        sq_r;
  logic [63:0]        sumsq_r, rem_r, root_r, bit_r;
  logic [31:0]        norm_r;
  logic [63:0]        num_r, quo_r;
  logic [32:0]        drem_r;
  logic [5:0]         dcnt_r;
  logic               neg_r;
  logic [31:0]        est_r, prev_r;
  logic [9:0]         passes_r;
  logic               zero_r;
  logic [31:0]        m_r;
  logic [4:0]         p_r, lcnt_r;
  logic [63:0]        msq_r;
  logic [15:0]        frac_r;
  result_t            res_r;
  logic               out_valid_r;

  logic signed [15:0] a_val;
  logic signed [51:0] y52;
  logic [51:0]        mag52;
  logic [47:0]        mag48;
  logic [63:0]        sq_t, root_step;
  logic               sq_ge;
  logic [32:0]        rsh;
  logic               d_ge;
  logic [31:0]        qclamp, diff;
  logic [32:0]        lt;
  logic [4:0]         n_clamp;
  logic               fin_go;
  logic [7:0]         int_part;

  assign q_ready = (state_r == S_IDLE);
  assign mem_we  = q_valid && q_ready;
  assign raddr   = {i_r[IdxW-1:0], j_r[IdxW-1:0]};
  assign a_val   = rd_vld_r ? rd_data_r : 16'sd0;
  assign y52     = acc_r >>> 8;
  assign mag52   = y52[51] ? 52'(-y52) : 52'(y52);
  assign mag48   = y_r[i_r[IdxW-1:0]][47] ? 48'(-y_r[i_r[IdxW-1:0]])
                                          : 48'(y_r[i_r[IdxW-1:0]]);
  assign sq_t      = root_r + bit_r;
  assign sq_ge     = rem_r >= sq_t;
  assign root_step = sq_ge ? (root_r >> 1) + bit_r : root_r >> 1;
  assign rsh     = {drem_r[31:0], num_r[63]};
  assign d_ge    = rsh >= {1'b0, norm_r};
  assign qclamp  = (quo_r > {32'd0, OneQ30}) ? OneQ30 : quo_r[31:0];
  assign diff    = (norm_r >= prev_r) ? norm_r - prev_r : prev_r - norm_r;
  assign lt      = msq_r[63:31];
  assign n_clamp = (act_r == 5'd0) ? 5'd1 : ((act_r > 5'(MaxStates)) ? 5'(MaxStates) : act_r);
  assign fin_go  = !out_valid_r || out_ch.ready;
  assign int_part = {3'b000, p_r} - 8'd16;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.eigen_estimate = res_r.eigen_estimate;
  assign out_ch.log2_capacity  = res_r.log2_capacity;
  assign out_ch.passes_used    = res_r.passes_used;
  assign out_ch.zero_norm      = res_r.zero_norm;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{q_item.entry_row, q_item.entry_col}] <= q_item.entry_value;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= ActiveReset;
      max_it_r <= MaxIterReset;
      tol_r    <= TolReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACTIVE_STATES: act_r    <= cfg_data[4:0];
        CFG_MAX_ITER:      max_it_r <= cfg_data[9:0];
        CFG_TOLERANCE:     tol_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= valid_r[raddr];
    unique case (state_r)
      S_MUL:  prod_r <= a_val * x_r[j_r[IdxW-1:0]];
      S_SQ:   sq_r   <= q_r * q_r;
      S_LSQ:  msq_r  <= m_r * m_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (mem_we) begin
            valid_r[{q_item.entry_row, q_item.entry_col}] <= 1'b1;
            if (q_item.last_entry) begin
              n_r      <= n_clamp;
              prev_r   <= 32'd0;
              est_r    <= 32'd0;
              zero_r   <= 1'b0;
              i_r      <= 5'd0;
              j_r      <= 5'd0;
              acc_r    <= '0;
              sumsq_r  <= '0;
              for (int k = 0; k < MaxStates; k++) begin
                x_r[k] <= OneQ30;
              end
              if (max_it_r == 10'd0) begin
                passes_r <= 10'd0;
                state_r  <= S_FIN;
              end else begin
                passes_r <= 10'd1;
                state_r  <= S_RD;
              end
            end
          end
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          acc_r <= acc_r + 52'(prod_r);
          j_r   <= j_r + 5'd1;
          state_r <= (j_r + 5'd1 == n_r) ? S_ROW : S_RD;
        end
        S_ROW: begin
          y_r[i_r[IdxW-1:0]] <= y52[47:0];
          q_r     <= mag52[41:14];
          state_r <= S_SQ;
        end
        S_SQ: state_r <= S_SUM;
        S_SUM: begin
          sumsq_r <= sumsq_r + 64'(sq_r);
          if (i_r + 5'd1 == n_r) begin
            rem_r   <= sumsq_r + 64'(sq_r);
            root_r  <= 64'd0;
            bit_r   <= 64'd1 << 62;
            state_r <= S_SQRT;
          end else begin
            i_r     <= i_r + 5'd1;
            j_r     <= 5'd0;
            acc_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            rem_r <= rem_r - sq_t;
          end
          root_r <= root_step;
          bit_r  <= bit_r >> 2;
          if (bit_r[0]) begin
            norm_r <= root_step[31:0];
            i_r    <= 5'd0;
            if (root_step == 64'd0) begin
              est_r   <= 32'd0;
              zero_r  <= 1'b1;
              state_r <= S_FIN;
            end else begin
              state_r <= S_DLD;
            end
          end
        end
        S_DLD: begin
          num_r   <= {mag48, 16'd0};
          neg_r   <= y_r[i_r[IdxW-1:0]][47];
          drem_r  <= 33'd0;
          quo_r   <= 64'd0;
          dcnt_r  <= 6'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          drem_r <= d_ge ? rsh - {1'b0, norm_r} : rsh;
          quo_r  <= {quo_r[62:0], d_ge};
          num_r  <= num_r << 1;
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd63) begin
            state_r <= S_DWB;
          end
        end
        S_DWB: begin
          x_r[i_r[IdxW-1:0]] <= neg_r ? -$signed(qclamp) : $signed(qclamp);
          if (i_r + 5'd1 == n_r) begin
            state_r <= S_CONV;
          end else begin
            i_r     <= i_r + 5'd1;
            state_r <= S_DLD;
          end
        end
        S_CONV: begin
          est_r <= norm_r;
          m_r   <= norm_r;
          p_r   <= 5'd31;
          if (diff < {16'd0, tol_r} || passes_r == max_it_r) begin
            state_r <= S_LNRM;
          end else begin
            prev_r   <= norm_r;
            passes_r <= passes_r + 10'd1;
            i_r      <= 5'd0;
            j_r      <= 5'd0;
            acc_r    <= '0;
            sumsq_r  <= '0;
            state_r  <= S_RD;
          end
        end
        S_LNRM: begin
          if (m_r[31]) begin
            lcnt_r  <= 5'd0;
            frac_r  <= 16'd0;
            state_r <= S_LSQ;
          end else begin
            m_r <= m_r << 1;
            p_r <= p_r - 5'd1;
          end
        end
        S_LSQ: state_r <= S_LST;
        S_LST: begin
          frac_r <= {frac_r[14:0], lt[32]};
          m_r    <= lt[32] ? lt[32:1] : lt[31:0];
          lcnt_r <= lcnt_r + 5'd1;
          state_r <= (lcnt_r == 5'd15) ? S_FIN : S_LSQ;
        end
        S_FIN: begin
          if (fin_go) begin
            res_r.eigen_estimate <= est_r;
            res_r.log2_capacity  <= (est_r == 32'd0) ? 24'sd0 : $signed({int_part, frac_r});
            res_r.passes_used    <= passes_r;
            res_r.zero_norm      <= zero_r;
            out_valid_r          <= 1'b1;
            valid_r              <= '0;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_store_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_go) |=> (valid_r == '0))
    else $error("matrix store not cleared after result");
  a_passes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (passes_r <= max_it_r))
    else $error("pass count beyond limit");
  a_vector_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWB) |-> (qclamp <= OneQ30))
    else $error("vector element above one");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (state_r != S_IDLE || out_valid_r))
    else $error("result dropped");
`endif

endmodule

/* rtl/power_iteration_spectral_radius.sv */
// Top level of the power-iteration dominant eigenvalue estimator.
//   channel   direction  carries
//   in_ch     in         one matrix entry, last_entry starts the computation
//   out_ch    out        eigenvalue, log2, pass count and zero flag
//   cfg_*     in         register writes, index and data
// An entry that is not last is only stored; entries stream at one per cycle while the engine is idle.
// A last entry runs up to the pass limit of passes over n rows, each through the multiply-accumulate
// loop (read, multiply, accumulate), the square root and the serial divider, then a log2 step.
// Input stalls once the two-entry queue fills; the result waits in its own register.
// Reset is synchronous and active low and restores the register defaults.
module power_iteration_spectral_radius (
  input  logic        clk,
  input  logic        rst_n,
  pisr_in_if.sink     in_ch,
  pisr_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  import pisr_pkg::*;

  item_t q_item;
  logic  q_valid, q_ready;

  pisr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  pisr_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_ch   (out_ch)
  );

endmodule

/* test/tb_power_iteration_spectral_radius.sv */
// Testbench for the power-iteration eigenvalue estimator, checked against its own predictor.
`timescale 1ns / 100ps
module tb_power_iteration_spectral_radius;
  import pisr_pkg::*;

  localparam int IdleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  pisr_in_if  in_ch();
  pisr_out_if out_ch();

  power_iteration_spectral_radius dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [15:0] model_matrix [Depth];
  logic [4:0]  model_states;
  logic [9:0]  model_iters;
  logic [15:0] model_tol;
  result_t     eigen_queue [$];
  int          fails = 0;
  int          sent = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;

  always @(negedge clk) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [23:0] log2_fixed(logic [31:0] val);
    int p;
    longint unsigned m;
    logic [15:0] frac;
    p = 31;
    frac = '0;
    while (val[p] == 1'b0) p--;
    m = longint'(val) << (31 - p);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m >>= 1;
      end
    end
    return 24'((p - 16) * 65536 + int'(frac));
  endfunction

  function automatic result_t predict_eigen();
    result_t r;
    int n;
    longint signed vec [MaxStates];
    longint signed prod [MaxStates];
    longint signed acc;
    longint unsigned sumsq, norm, mag, q, qx;
    logic [31:0] est, prev, diff;
    int passes;
    bit zero;
    n = (model_states == 0) ? 1 : (model_states > MaxStates ? MaxStates : model_states);
    for (int i = 0; i < MaxStates; i++) vec[i] = 64'sd1 << 30;
    prev = '0;
    est = '0;
    passes = 0;
    zero = 1'b0;
    for (int it = 0; it < model_iters; it++) begin
      passes = it + 1;
      sumsq = 0;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) acc += longint'(model_matrix[i * MaxStates + j]) * vec[j];
        prod[i] = acc >>> 8;
        mag = prod[i] < 0 ? -prod[i] : prod[i];
        q = mag >> 14;
        sumsq += q * q;
      end
      norm = int_sqrt(sumsq);
      if (norm == 0) begin
        est = '0;
        zero = 1'b1;
        break;
      end
      for (int i = 0; i < n; i++) begin
        mag = prod[i] < 0 ? -prod[i] : prod[i];
        qx = (mag << 16) / norm;
        if (qx > (64'd1 << 30)) qx = 64'd1 << 30;
        vec[i] = prod[i] < 0 ? -longint'(qx) : longint'(qx);
      end
      est = norm > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : norm[31:0];
      diff = est >= prev ? est - prev : prev - est;
      if (diff < model_tol) break;
      prev = est;
    end
    r.eigen_estimate = est;
    r.log2_capacity = (est != 0) ? log2_fixed(est) : '0;
    r.passes_used = passes[9:0];
    r.zero_norm = zero;
    return r;
  endfunction

  task automatic send_entry(logic [3:0] row, logic [3:0] col, logic signed [15:0] value,
                            logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 20) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.entry_row = row;
    in_ch.entry_col = col;
    in_ch.entry_value = value;
    in_ch.last_entry = last;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    model_matrix[{row, col}] = value;
    if (last) begin
      eigen_queue.push_back(predict_eigen());
      for (int i = 0; i < Depth; i++) model_matrix[i] = '0;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (eigen_queue.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ACTIVE_STATES: model_states = data[4:0];
      CFG_MAX_ITER:      model_iters = data[9:0];
      CFG_TOLERANCE:     model_tol = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
    if (out_ch.valid && out_ch.ready) begin
      if (eigen_queue.size() == 0) begin
        $display("%0t unexpected result: actual %h %h %h %b", $time, out_ch.eigen_estimate,
                 out_ch.log2_capacity, out_ch.passes_used, out_ch.zero_norm);
        fails++;
      end else begin
        result_t e;
        e = eigen_queue.pop_front();
        if (out_ch.eigen_estimate !== e.eigen_estimate) begin
          $display("%0t eigen_estimate: expected %h actual %h", $time, e.eigen_estimate,
                   out_ch.eigen_estimate);
          fails++;
        end
        if (out_ch.log2_capacity !== e.log2_capacity) begin
          $display("%0t log2_capacity: expected %h actual %h", $time, e.log2_capacity,
                   out_ch.log2_capacity);
          fails++;
        end
        if (out_ch.passes_used !== e.passes_used) begin
          $display("%0t passes_used: expected %0d actual %0d", $time, e.passes_used,
                   out_ch.passes_used);
          fails++;
        end
        if (out_ch.zero_norm !== e.zero_norm) begin
          $display("%0t zero_norm: expected %b actual %b", $time, e.zero_norm,
                   out_ch.zero_norm);
          fails++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_entry(4'd0, 4'd0, 16'sd256, 1'b1);
  endtask

  task automatic test_entry_extremes();
    write_reg(CFG_MAX_ITER, 16'd4);
    send_entry(4'd0, 4'd0, -16'sd32768, 1'b0);
    send_entry(4'd15, 4'd15, 16'sd32767, 1'b0);
    send_entry(4'd0, 4'd15, 16'sd32767, 1'b0);
    send_entry(4'd15, 4'd0, -16'sd32768, 1'b1);
    write_reg(CFG_ACTIVE_STATES, 16'd2);
    send_entry(4'd1, 4'd1, -16'sd1, 1'b0);
    send_entry(4'd9, 4'd3, 16'sd32767, 1'b0);
    send_entry(4'd0, 4'd1, 16'sd1, 1'b1);
  endtask

  task automatic test_zero_norm();
    send_entry(4'd0, 4'd0, 16'sd0, 1'b1);
    send_entry(4'd5, 4'd5, 16'sd1000, 1'b1);
    send_entry(4'd0, 4'd0, 16'sd1, 1'b1);
  endtask

  task automatic test_register_corners();
    write_reg(CFG_MAX_ITER, 16'd3);
    write_reg(CFG_ACTIVE_STATES, 16'd31);
    send_entry(4'd15, 4'd15, 16'sd700, 1'b0);
    send_entry(4'd3, 4'd15, -16'sd300, 1'b1);
    write_reg(CFG_ACTIVE_STATES, 16'd0);
    send_entry(4'd0, 4'd0, -16'sd512, 1'b1);
    write_reg(CFG_MAX_ITER, 16'd0);
    send_entry(4'd0, 4'd0, 16'sd256, 1'b1);
    write_reg(CFG_ACTIVE_STATES, 16'd1);
    write_reg(CFG_MAX_ITER, 16'd1023);
    write_reg(CFG_TOLERANCE, 16'd0);
    send_entry(4'd0, 4'd0, 16'sd32767, 1'b1);
    write_reg(CFG_TOLERANCE, 16'd65535);
    send_entry(4'd0, 4'd0, 16'sd300, 1'b1);
    write_reg(CFG_TOLERANCE, 16'd1);
  endtask

  task automatic test_random_matrices();
    int n, cnt;
    logic signed [15:0] v;
    while (sent < 1850) begin
      steady = (sent > 700 && sent < 1000);
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(16, 5);
        write_reg(CFG_MAX_ITER, 16'($urandom_range(4, 1)));
      end else begin
        n = $urandom_range(4, 1);
        write_reg(CFG_MAX_ITER, 16'($urandom_range(40, 1)));
      end
      write_reg(CFG_ACTIVE_STATES, 16'(n));
      case ($urandom_range(3))
        0: write_reg(CFG_TOLERANCE, 16'd0);
        1: write_reg(CFG_TOLERANCE, 16'($urandom));
        default: write_reg(CFG_TOLERANCE, 16'($urandom_range(64)));
      endcase
      cnt = $urandom_range(2 * n * n + 2);
      for (int k = 0; k < cnt; k++) begin
        v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(1024)) - 512);
        if ($urandom_range(7) == 0)
          send_entry(4'($urandom), 4'($urandom), v, 1'b0);
        else
          send_entry(4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)), v, 1'b0);
      end
      send_entry(4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)), 16'($urandom), 1'b1);
    end
    steady = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.entry_row = '0;
    in_ch.entry_col = '0;
    in_ch.entry_value = '0;
    in_ch.last_entry = 1'b0;
    for (int i = 0; i < Depth; i++) model_matrix[i] = '0;
    model_states = ActiveReset;
    model_iters = MaxIterReset;
    model_tol = TolReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_entry_extremes();
    test_zero_norm();
    test_register_corners();
    test_random_matrices();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (eigen_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* power_iteration_spectral_radius.f */
rtl/pisr_pkg.sv
rtl/pisr_if.sv
rtl/pisr_front.sv
rtl/pisr_engine.sv
rtl/power_iteration_spectral_radius.sv
test/tb_power_iteration_spectral_radius.sv
